@@ rtl/pfbb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbb_pkg
// Shared types, codes and widths of the page framebuffer bit blitter.
// ----------------------------------------------------------------------------
package pfbb_pkg;

    // default geometry of the store
    localparam int SCREEN_COLUMNS_DEF = 64;
    localparam int PAGE_COUNT_DEF     = 3;
    localparam int BYTE_ROWS_DEF      = 4;

    // stream and configuration widths
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 1;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // byte row arithmetic: base row plus source row plus one stays below 8,
    // one more bit lets the row bound itself be 8
    localparam int ROW_W = 4;

    localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

    // request kinds carried on s_tuser
    typedef enum logic [1:0] {
        KIND_BLIT  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_PLOT  = 2'd3
    } kind_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BLIT_X         = 3'd0,
        CFG_BLIT_Y         = 3'd1,
        CFG_BLIT_PAGE      = 3'd2,
        CFG_INVERT_SOURCE  = 3'd3,
        CFG_OVERWRITE_MODE = 3'd4
    } cfg_index_t;

endpackage

@@ rtl/page_framebuffer_bit_blitter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_bit_blitter_unit
// Monochrome page framebuffer with byte blit, pixel plot and raw access.
// ----------------------------------------------------------------------------
// The store sits in one simple dual-port RAM of BYTE_ROWS * SCREEN_COLUMNS *
// PAGE_COUNT bytes (768 by default), each byte eight vertical pixels with the
// top pixel in bit 0. After reset a clearing pass writes zero to one byte per
// cycle, so s_tready stays low until every byte is cleared; configuration writes
// are taken during that pass. A request is then taken in the idle cycle, where the
// target byte is read, and the byte is merged and written back in the next cycle:
// reads, writes, plots and blits with a zero bit offset then return to idle, a blit
// with a nonzero bit offset goes through a second state because its second byte row
// is read while the first is written and is written in the cycle after. The single
// read and single write port of the RAM set this order. Each request yields one
// response; an output register plus one skid entry let one more request be taken
// while a response waits.
// ----------------------------------------------------------------------------
module page_framebuffer_bit_blitter_unit #(
    parameter int SCREEN_COLUMNS = pfbb_pkg::SCREEN_COLUMNS_DEF,
    parameter int PAGE_COUNT     = pfbb_pkg::PAGE_COUNT_DEF,
    parameter int BYTE_ROWS      = pfbb_pkg::BYTE_ROWS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // column[7:0], byte_row[9:8], data_byte[17:10], pixel_y[22:18],
    // pixel_xor[23]
    input  logic [pfbb_pkg::S_TDATA_W-1:0]     s_tdata,
    // kind[1:0]
    input  logic [pfbb_pkg::S_TUSER_W-1:0]     s_tuser,
    // response stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // read_data[7:0]
    output logic [pfbb_pkg::M_TDATA_W-1:0]     m_tdata,
    // dropped[0]
    output logic [pfbb_pkg::M_TUSER_W-1:0]     m_tuser,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [pfbb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pfbb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int TOTAL_COLUMNS = SCREEN_COLUMNS * PAGE_COUNT;
    localparam int DEPTH         = BYTE_ROWS * TOTAL_COLUMNS;
    localparam int ADDR_W        = $clog2(DEPTH);
    // page base plus two 8-bit offsets
    localparam int COL_W         = $clog2(3 * SCREEN_COLUMNS + 512);
    localparam int ROW_W         = pfbb_pkg::ROW_W;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_FIRST  = 4'b0100,
        ST_SECOND = 4'b1000
    } state_t;

    // configuration registers
    logic [7:0] blit_x_reg;
    logic [4:0] blit_y_reg;
    logic [1:0] blit_page_reg;
    logic       invert_source_reg;
    logic       overwrite_mode_reg;

    // control
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg;

    // request captured at accept
    pfbb_pkg::kind_t   kind_reg, kind_next;
    logic [ADDR_W-1:0] addr_a_reg, addr_a_next;
    logic [ADDR_W-1:0] addr_b_reg, addr_b_next;
    logic              ok_a_reg, ok_a_next;
    logic              ok_b_reg, ok_b_next;
    logic              need_b_reg, need_b_next;
    logic              drop_reg, drop_next;
    logic [2:0]        l_reg, l_next;
    logic [7:0]        lo_reg, lo_next;
    logic [7:0]        hi_reg, hi_next;
    logic              pxor_reg;

    // response buffering
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tuser_reg, m_tuser_next;
    logic       skid_valid_reg, skid_valid_next;
    logic [7:0] skid_data_reg, skid_data_next;
    logic       skid_drop_reg, skid_drop_next;

    // request fields
    logic [7:0] in_column;
    logic [1:0] in_byte_row;
    logic [7:0] in_data;
    logic [4:0] in_pixel_y;
    logic       in_pixel_xor;

    logic              accept;
    logic              out_free;
    logic              res_fire;
    logic [7:0]        res_data;
    logic [COL_W-1:0]  page_base;
    logic [COL_W-1:0]  tgt_col;
    logic [ROW_W-1:0]  tgt_row;
    logic [ROW_W-1:0]  row_b;
    logic              col_ok;
    logic [7:0]        src;
    logic [15:0]       src_shift;
    logic [7:0]        keep_lo;
    logic [7:0]        keep_hi;

    // ram ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    assign in_column    = s_tdata[7:0];
    assign in_byte_row  = s_tdata[9:8];
    assign in_data      = s_tdata[17:10];
    assign in_pixel_y   = s_tdata[22:18];
    assign in_pixel_xor = s_tdata[23];

    assign s_tready = (state_reg == ST_IDLE) && !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blit_x_reg         <= '0;
            blit_y_reg         <= '0;
            blit_page_reg      <= '0;
            invert_source_reg  <= 1'b0;
            overwrite_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pfbb_pkg::CFG_BLIT_X:         blit_x_reg         <= cfg_data[7:0];
                pfbb_pkg::CFG_BLIT_Y:         blit_y_reg         <= cfg_data[4:0];
                pfbb_pkg::CFG_BLIT_PAGE:      blit_page_reg      <= cfg_data[1:0];
                pfbb_pkg::CFG_INVERT_SOURCE:  invert_source_reg  <= cfg_data[0];
                pfbb_pkg::CFG_OVERWRITE_MODE: overwrite_mode_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // target address and range checks for the incoming request
    always_comb
    begin
        page_base   = COL_W'(32'(blit_page_reg) * SCREEN_COLUMNS);
        src         = invert_source_reg ? ~in_data : in_data;
        src_shift   = {8'h00, src} << blit_y_reg[2:0];
        kind_next   = pfbb_pkg::kind_t'(s_tuser);
        l_next      = blit_y_reg[2:0];
        need_b_next = 1'b0;
        tgt_row     = ROW_W'(in_byte_row);
        tgt_col     = COL_W'(in_column);
        lo_next     = in_data;
        hi_next     = src_shift[15:8];
        unique case (kind_next)
            pfbb_pkg::KIND_BLIT:
            begin
                tgt_row     = ROW_W'(blit_y_reg[4:3]) + ROW_W'(in_byte_row);
                tgt_col     = page_base + COL_W'(blit_x_reg) + COL_W'(in_column);
                lo_next     = src_shift[7:0];
                need_b_next = (blit_y_reg[2:0] != 3'd0);
            end
            pfbb_pkg::KIND_READ,
            pfbb_pkg::KIND_WRITE:
            begin
            end
            pfbb_pkg::KIND_PLOT:
            begin
                tgt_row = ROW_W'(in_pixel_y[4:3]);
                tgt_col = page_base + COL_W'(in_column);
                lo_next = 8'h01 << in_pixel_y[2:0];
            end
            default:
            begin
            end
        endcase
        row_b  = tgt_row + ROW_W'(1);
        col_ok = tgt_col < COL_W'(TOTAL_COLUMNS);
        ok_a_next = col_ok && (tgt_row < ROW_W'(BYTE_ROWS));
        if (kind_next == pfbb_pkg::KIND_PLOT)
        begin
            ok_a_next = ok_a_next
                && ({1'b0, in_column} < 9'(SCREEN_COLUMNS))
                && ({2'b00, in_pixel_y} < 7'(BYTE_ROWS * 8));
        end
        ok_b_next   = col_ok && (row_b < ROW_W'(BYTE_ROWS));
        addr_a_next = ADDR_W'(32'(tgt_row) * TOTAL_COLUMNS + 32'(tgt_col));
        addr_b_next = ADDR_W'(32'(row_b) * TOTAL_COLUMNS + 32'(tgt_col));
        drop_next   = !ok_a_next || (need_b_next && !ok_b_next);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                state_next = need_b_reg ? ST_SECOND : ST_IDLE;
            end
            ST_SECOND:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    // capture the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind_next;
            addr_a_reg <= addr_a_next;
            addr_b_reg <= addr_b_next;
            ok_a_reg   <= ok_a_next;
            ok_b_reg   <= ok_b_next;
            need_b_reg <= need_b_next;
            drop_reg   <= drop_next;
            l_reg      <= l_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            pxor_reg   <= in_pixel_xor;
        end
    end

    // read-modify-write of the store
    always_comb
    begin
        keep_lo   = ~(pfbb_pkg::BYTE_ALL_ONES << l_reg);
        keep_hi   = pfbb_pkg::BYTE_ALL_ONES << l_reg;
        ram_we    = 1'b0;
        ram_waddr = addr_a_reg;
        ram_wdata = 8'h00;
        ram_raddr = addr_a_reg;
        res_fire  = 1'b0;
        res_data  = 8'h00;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
            end
            ST_IDLE:
            begin
                ram_raddr = addr_a_next;
            end
            ST_FIRST:
            begin
                ram_raddr = addr_b_reg;
                res_fire  = !need_b_reg;
                unique case (kind_reg)
                    pfbb_pkg::KIND_BLIT:
                    begin
                        ram_we    = ok_a_reg;
                        ram_wdata = (overwrite_mode_reg ? (ram_rdata & keep_lo) : ram_rdata)
                            | lo_reg;
                    end
                    pfbb_pkg::KIND_READ:
                    begin
                        res_data = ok_a_reg ? ram_rdata : 8'h00;
                    end
                    pfbb_pkg::KIND_WRITE:
                    begin
                        ram_we    = ok_a_reg;
                        ram_wdata = lo_reg;
                    end
                    pfbb_pkg::KIND_PLOT:
                    begin
                        ram_we    = ok_a_reg;
                        ram_wdata = pxor_reg ? (ram_rdata ^ lo_reg) : (ram_rdata | lo_reg);
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SECOND:
            begin
                ram_we    = ok_b_reg;
                ram_waddr = addr_b_reg;
                ram_wdata = (overwrite_mode_reg ? (ram_rdata & keep_hi) : ram_rdata) | hi_reg;
                res_fire  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    pfbb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register with one skid entry
    always_comb
    begin
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_drop_next  = skid_drop_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                m_tvalid_next   = 1'b1;
                m_tdata_next    = skid_data_reg;
                m_tuser_next    = skid_drop_reg;
                skid_valid_next = 1'b0;
            end
            else if (res_fire)
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = res_data;
                m_tuser_next  = drop_reg;
            end
            else
            begin
                m_tvalid_next = 1'b0;
            end
        end
        else if (res_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
            skid_drop_next  = drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg   <= m_tvalid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        skid_data_reg <= skid_data_next;
        skid_drop_reg <= skid_drop_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ rtl/pfbb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pfbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pfbb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbb_checker
// Port-level checks of the page framebuffer bit blitter, bound to the top.
// ----------------------------------------------------------------------------
module pfbb_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [pfbb_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic [pfbb_pkg::M_TUSER_W-1:0]     m_tuser
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    // requests taken but not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (s_tvalid && s_tready && !(m_tvalid && m_tready))
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!(s_tvalid && s_tready) && m_tvalid && m_tready)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // clearing pass keeps requests out right after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !s_tready)
        else $error("request taken before clearing pass");

    // no two requests are taken back to back
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken in consecutive cycles");

    // at most two requests in the block, no response without a request
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd2 |-> !s_tready)
        else $error("third request taken while two are pending");

    a_response_owed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 2'd0)
        else $error("response without a request");

    // a dropped target never carries read data
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("dropped response with nonzero read data");

endmodule

bind page_framebuffer_bit_blitter_unit pfbb_checker u_pfbb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ bench/page_framebuffer_bit_blitter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_bit_blitter_unit_tb
// Self-checking bench for the page framebuffer bit blitter.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the 4 x 192 byte store and of the five
// configuration registers. Every request taken on the input stream is run
// through that copy, and the response it predicts is queued. Every response
// taken on the output stream is checked against the oldest queued one. A
// short directed pass hits the store edges, every request kind, both merge
// modes, source inversion and dropped targets. Random phases with fresh
// register settings follow, with random gaps on both streams and one long
// output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module page_framebuffer_bit_blitter_unit_tb;

    import pfbb_pkg::*;

    localparam int COLUMNS_PER_PAGE = SCREEN_COLUMNS_DEF;
    localparam int STORE_COLUMNS    = SCREEN_COLUMNS_DEF * PAGE_COUNT_DEF;
    localparam int STORE_ROWS       = BYTE_ROWS_DEF;
    localparam int STORE_BYTES      = STORE_ROWS * STORE_COLUMNS;
    localparam int PIXEL_ROWS       = BYTE_ROWS_DEF * 8;
    localparam int RESET_CYCLES     = 12;
    localparam int SETTLE_CYCLES    = 6;
    localparam int HOLD_CYCLES      = 400;
    localparam int RANDOM_PHASES    = 10;
    localparam int PHASE_REQUESTS   = 125;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int REPORT_LIMIT     = 10;

    // one predicted response
    typedef struct packed {
        logic [7:0] read_data;
        logic       dropped;
    } response_t;

    // ------------------------------------------------------------------------
    // scoreboard: store copy, register copy and pending responses
    // ------------------------------------------------------------------------
    class blit_scoreboard;
        logic [7:0] pixels [STORE_BYTES];
        logic [7:0] reg_blit_x;
        logic [4:0] reg_blit_y;
        logic [1:0] reg_page;
        logic       reg_invert;
        logic       reg_overwrite;
        response_t  pending [$];
        int         mismatches;
        int         responses;
        int         drops;
        int         kind_seen [4];

        function new();
            foreach (pixels[i])
                pixels[i] = 8'h00;
            reg_blit_x    = 8'd0;
            reg_blit_y    = 5'd0;
            reg_page      = 2'd0;
            reg_invert    = 1'b0;
            reg_overwrite = 1'b0;
            mismatches    = 0;
            responses     = 0;
            drops         = 0;
            foreach (kind_seen[i])
                kind_seen[i] = 0;
        endfunction

        function void set_reg(cfg_index_t index, logic [7:0] value);
            case (index)
                CFG_BLIT_X:         reg_blit_x    = value;
                CFG_BLIT_Y:         reg_blit_y    = value[4:0];
                CFG_BLIT_PAGE:      reg_page      = value[1:0];
                CFG_INVERT_SOURCE:  reg_invert    = value[0];
                CFG_OVERWRITE_MODE: reg_overwrite = value[0];
                default: ;
            endcase
        endfunction

        function bit in_store(int row, int col);
            return row < STORE_ROWS && col < STORE_COLUMNS;
        endfunction

        // merge bits into one store byte, zero when the byte is off the store
        function bit merge_into(int row, int col, logic [7:0] bits, logic [7:0] keep);
            logic [7:0] kept;
            if (!in_store(row, col))
                return 1'b0;
            kept = pixels[row * STORE_COLUMNS + col];
            if (reg_overwrite)
                kept = kept & keep;
            pixels[row * STORE_COLUMNS + col] = kept | bits;
            return 1'b1;
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        // run one taken request through the store copy
        function void note_request(kind_t kind, logic [7:0] column, logic [1:0] byte_row,
                                   logic [7:0] data_byte, logic [4:0] pixel_y,
                                   logic pixel_xor);
            response_t  resp;
            int         shift;
            int         row;
            int         col;
            logic [7:0] src;
            logic [15:0] spread;
            logic [7:0] low_keep;
            logic [7:0] high_keep;
            resp.read_data = 8'h00;
            resp.dropped   = 1'b0;
            kind_seen[kind]++;
            case (kind)
                KIND_BLIT:
                begin
                    shift     = int'(reg_blit_y[2:0]);
                    row       = int'(reg_blit_y[4:3]) + int'(byte_row);
                    col       = int'(reg_page) * COLUMNS_PER_PAGE + int'(reg_blit_x)
                                + int'(column);
                    src       = reg_invert ? ~data_byte : data_byte;
                    spread    = {8'h00, src} << shift;
                    high_keep = BYTE_ALL_ONES << shift;
                    low_keep  = ~high_keep;
                    if (!merge_into(row, col, spread[7:0], low_keep))
                        resp.dropped = 1'b1;
                    if (shift != 0 && !merge_into(row + 1, col, spread[15:8], high_keep))
                        resp.dropped = 1'b1;
                end
                KIND_READ:
                begin
                    if (in_store(int'(byte_row), int'(column)))
                        resp.read_data = pixels[int'(byte_row) * STORE_COLUMNS + int'(column)];
                    else
                        resp.dropped = 1'b1;
                end
                KIND_WRITE:
                begin
                    if (in_store(int'(byte_row), int'(column)))
                        pixels[int'(byte_row) * STORE_COLUMNS + int'(column)] = data_byte;
                    else
                        resp.dropped = 1'b1;
                end
                default:
                begin
                    col = int'(reg_page) * COLUMNS_PER_PAGE + int'(column);
                    row = int'(pixel_y[4:3]);
                    if (int'(column) >= COLUMNS_PER_PAGE || int'(pixel_y) >= PIXEL_ROWS
                        || !in_store(row, col))
                        resp.dropped = 1'b1;
                    else if (pixel_xor)
                        pixels[row * STORE_COLUMNS + col] ^= (8'h01 << pixel_y[2:0]);
                    else
                        pixels[row * STORE_COLUMNS + col] |= (8'h01 << pixel_y[2:0]);
                end
            endcase
            if (resp.dropped)
                drops++;
            pending.push_back(resp);
        endfunction

        function void flag_mismatch(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        // compare one taken response with the oldest prediction
        function void check_response(logic [7:0] read_data, logic dropped);
            response_t want;
            responses++;
            if (pending.size() == 0)
            begin
                flag_mismatch($sformatf("response read_data=%02h dropped=%0b with no request",
                                        read_data, dropped));
                return;
            end
            want = pending.pop_front();
            if (read_data !== want.read_data)
                flag_mismatch($sformatf("read_data expected %02h got %02h",
                                        want.read_data, read_data));
            if (dropped !== want.dropped)
                flag_mismatch($sformatf("dropped expected %0b got %0b",
                                        want.dropped, dropped));
        endfunction

        // predictions never answered
        function void close_out();
            while (pending.size() != 0)
            begin
                void'(pending.pop_front());
                flag_mismatch("response never arrived");
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // column, byte_row, data_byte, pixel_y, pixel_xor
    logic [S_TUSER_W-1:0]   s_tuser   = '0;   // kind
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // read_data
    logic [M_TUSER_W-1:0]   m_tuser;          // dropped
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    blit_scoreboard book;
    int  cycle_count     = 0;
    bit  sender_idles    = 1'b0;
    bit  receiver_idles  = 1'b0;
    bit  squeeze_request = 1'b0;
    bit  squeeze_done    = 1'b0;

    page_framebuffer_bit_blitter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock and cycle count
    always #10 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // run limit
    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // monitor both streams at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                book.check_response(m_tdata, m_tuser[0]);
            if (s_tvalid && s_tready)
                book.note_request(kind_t'(s_tuser), s_tdata[7:0], s_tdata[9:8],
                                  s_tdata[17:10], s_tdata[22:18], s_tdata[23]);
        end
    end

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    // response side: random stalls plus one long hold-off
    initial
    begin
        int stall_left;
        int held;
        int gap;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (squeeze_request && !squeeze_done)
            begin
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge clk);
                squeeze_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                gap = receiver_idles ? pick_gap() : 0;
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    stall_left = gap - 1;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    // offer one request, called and returning at a falling edge
    task automatic send_request(kind_t kind, logic [7:0] column, logic [1:0] byte_row,
                                logic [7:0] data_byte, logic [4:0] pixel_y,
                                logic pixel_xor);
        int gap;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {pixel_xor, pixel_y, data_byte, byte_row, column};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // wait until every response is back and the block has settled
    task automatic drain_idle();
        s_tvalid <= 1'b0;
        while (book.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // write all five registers back to back while idle
    task automatic set_config(logic [7:0] blit_x, logic [4:0] blit_y, logic [1:0] page,
                              logic invert, logic overwrite);
        cfg_index_t idx [5];
        logic [7:0] val [5];
        drain_idle();
        idx = '{CFG_BLIT_X, CFG_BLIT_Y, CFG_BLIT_PAGE, CFG_INVERT_SOURCE,
                CFG_OVERWRITE_MODE};
        val = '{blit_x, {3'b000, blit_y}, {6'b0, page}, {7'b0, invert}, {7'b0, overwrite}};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            book.set_reg(idx[i], val[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // one random request, mostly aimed inside the store
    task automatic send_random_request();
        kind_t      kind;
        int         r;
        logic [7:0] column;
        r = $urandom_range(0, 99);
        if (r < 40)
            kind = KIND_BLIT;
        else if (r < 65)
            kind = KIND_READ;
        else if (r < 80)
            kind = KIND_WRITE;
        else
            kind = KIND_PLOT;
        r = $urandom_range(0, 9);
        case (kind)
            KIND_READ, KIND_WRITE:
                column = (r < 8) ? 8'($urandom_range(0, STORE_COLUMNS - 1))
                                 : 8'($urandom_range(0, 255));
            default:
                column = (r < 8) ? 8'($urandom_range(0, COLUMNS_PER_PAGE - 1))
                                 : 8'($urandom_range(0, 255));
        endcase
        send_request(kind, column, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0] pick_x;
        logic [4:0] pick_y;
        logic [1:0] pick_page;
        book = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: raw access at the store edges, plots and plain blits
        set_config(8'd0, 5'd0, 2'd0, 1'b0, 1'b0);
        send_request(KIND_WRITE, 8'd0,   2'd0, 8'hFF, 5'd0,  1'b0);
        send_request(KIND_READ,  8'd0,   2'd0, 8'h00, 5'd0,  1'b0);
        send_request(KIND_WRITE, 8'd191, 2'd3, 8'hA5, 5'd31, 1'b1);
        send_request(KIND_READ,  8'd191, 2'd3, 8'h00, 5'd0,  1'b0);
        send_request(KIND_WRITE, 8'd192, 2'd0, 8'h3C, 5'd0,  1'b0);
        send_request(KIND_READ,  8'd255, 2'd3, 8'hFF, 5'd31, 1'b1);
        send_request(KIND_PLOT,  8'd0,   2'd0, 8'h00, 5'd0,  1'b0);
        send_request(KIND_PLOT,  8'd63,  2'd0, 8'h00, 5'd31, 1'b1);
        send_request(KIND_PLOT,  8'd64,  2'd0, 8'h00, 5'd5,  1'b0);
        send_request(KIND_PLOT,  8'd255, 2'd3, 8'hFF, 5'd31, 1'b1);
        send_request(KIND_BLIT,  8'd1,   2'd0, 8'h81, 5'd0,  1'b0);
        send_request(KIND_READ,  8'd1,   2'd0, 8'h00, 5'd0,  1'b0);

        // directed: inverted overwrite with offset, second byte off the bottom,
        // both bytes off the right edge
        set_config(8'd60, 5'd13, 2'd2, 1'b1, 1'b1);
        send_request(KIND_BLIT,  8'd3,   2'd2, 8'h0F, 5'd0,  1'b0);
        send_request(KIND_BLIT,  8'd0,   2'd0, 8'hF0, 5'd0,  1'b0);
        send_request(KIND_BLIT,  8'd4,   2'd0, 8'h55, 5'd0,  1'b0);
        send_request(KIND_READ,  8'd188, 2'd1, 8'h00, 5'd0,  1'b0);
        send_request(KIND_READ,  8'd188, 2'd2, 8'h00, 5'd0,  1'b0);
        send_request(KIND_READ,  8'd191, 2'd3, 8'h00, 5'd0,  1'b0);

        // directed: register extremes and a page past the store
        set_config(8'd255, 5'd31, 2'd3, 1'b0, 1'b0);
        send_request(KIND_BLIT,  8'd255, 2'd3, 8'hFF, 5'd31, 1'b1);
        send_request(KIND_PLOT,  8'd10,  2'd0, 8'h00, 5'd3,  1'b0);

        // directed: overwrite with offset seven keeps bits outside the picture
        set_config(8'd0, 5'd7, 2'd1, 1'b0, 1'b1);
        send_request(KIND_WRITE, 8'd64,  2'd0, 8'h5A, 5'd0,  1'b0);
        send_request(KIND_WRITE, 8'd64,  2'd1, 8'hC3, 5'd0,  1'b0);
        send_request(KIND_BLIT,  8'd0,   2'd0, 8'hFF, 5'd0,  1'b0);
        send_request(KIND_READ,  8'd64,  2'd0, 8'h00, 5'd0,  1'b0);
        send_request(KIND_READ,  8'd64,  2'd1, 8'h00, 5'd0,  1'b0);
        send_request(KIND_PLOT,  8'd0,   2'd0, 8'h00, 5'd8,  1'b1);
        send_request(KIND_READ,  8'd64,  2'd1, 8'h00, 5'd0,  1'b0);

        // random phases, each with fresh registers and its own idle pattern
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                set_config(8'd191, 5'd0, 2'd2, 1'b1, 1'b0);
            else
            begin
                case ($urandom_range(0, 5))
                    0:       pick_x = 8'd0;
                    1:       pick_x = 8'd191;
                    2:       pick_x = 8'd255;
                    default: pick_x = 8'($urandom_range(0, COLUMNS_PER_PAGE - 1));
                endcase
                case ($urandom_range(0, 5))
                    0:       pick_y = 5'd0;
                    1:       pick_y = 5'd31;
                    default: pick_y = 5'($urandom_range(0, 31));
                endcase
                pick_page = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                set_config(pick_x, pick_y, pick_page, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            end
            sender_idles   = (phase % 3) != 0;
            receiver_idles = (phase % 4) != 1;
            if (phase == 1)
                squeeze_request = 1'b1;
            for (int n = 0; n < PHASE_REQUESTS; n++)
                send_random_request();
        end

        drain_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        book.close_out();

        $display("covered %0d responses: %0d blit, %0d read, %0d write, %0d plot, %0d dropped",
                 book.responses, book.kind_seen[KIND_BLIT], book.kind_seen[KIND_READ],
                 book.kind_seen[KIND_WRITE], book.kind_seen[KIND_PLOT], book.drops);
        $display("%0d register settings, %0d cycles, %0d mismatches",
                 RANDOM_PHASES + 4, cycle_count, book.mismatches);
        if (book.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
